// File: rtl/montgomery_modular_multiplier_assert.svh
// ----------------------------------------------------------------------------
// Montgomery multiplier assertion macros
// Concurrent assertion shorthands shared by the multiplier RTL. They expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_MODULAR_MULTIPLIER_ASSERT_SVH
`define MONTGOMERY_MODULAR_MULTIPLIER_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent holds in the same cycle as the antecedent.
`define MMM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MMM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define MMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/mmm_pkg.sv
// ----------------------------------------------------------------------------
// Montgomery multiplier package
// Word count, beat types and the multiply-accumulate unit interface.
// ----------------------------------------------------------------------------
package mmm_pkg;

  // Number of 64-bit words per operand
  localparam int WORDS = 2;
  localparam int DATA_W = 64;

  // Word index width and the index of the most significant word
  localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WORDS - 1);

  // Inverse lifting runs over bit positions 1 to 63
  localparam int INV_CNT_W = 6;
  localparam logic [INV_CNT_W-1:0] INV_FIRST = 6'd1;
  localparam logic [INV_CNT_W-1:0] INV_LAST = 6'd63;

  // Multiply-accumulate sequencer: four partial products, last add on step 4
  localparam int MAC_STEP_W = 3;
  localparam logic [MAC_STEP_W-1:0] MAC_LAST_STEP = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] x_word;
    logic [DATA_W-1:0] y_word;
    logic [DATA_W-1:0] modulus_word;
  } in_item_t;

  localparam int OPND_W = $bits(in_item_t);

  typedef struct packed {
    logic [DATA_W-1:0] result_word;
    logic              last_word;
  } out_item_t;

  // hi:lo = a*b + c + d
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] d;
  } mac_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } mac_rsp_t;

endpackage

// File: rtl/mmm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mmm_mac.sv
// ----------------------------------------------------------------------------
// Montgomery multiplier multiply-accumulate unit
// Computes hi:lo = a*b + c + d with one 32x32 multiplier:
// one partial product per cycle, each registered before it is accumulated.
// ----------------------------------------------------------------------------
`include "montgomery_modular_multiplier_assert.svh"

module mmm_mac (
  input  logic              clk,
  input  logic              rst,
  input  mmm_pkg::mac_cmd_t cmd,
  output mmm_pkg::mac_rsp_t rsp
);

  logic                               busy;
  logic                               done;
  logic [mmm_pkg::MAC_STEP_W-1:0]     step;
  logic [mmm_pkg::DATA_W-1:0]         a_reg;
  logic [mmm_pkg::DATA_W-1:0]         b_reg;
  logic [2*mmm_pkg::DATA_W-1:0]       acc;
  logic [mmm_pkg::DATA_W-1:0]         prod;
  logic [1:0]                         prod_pos;
  logic [mmm_pkg::DATA_W/2-1:0]       a_half;
  logic [mmm_pkg::DATA_W/2-1:0]       b_half;
  logic [mmm_pkg::DATA_W-1:0]         prod_next;
  logic [2*mmm_pkg::DATA_W-1:0]       addend;

  // Pick the halves for this step: lo*lo, lo*hi, hi*lo, hi*hi
  assign a_half    = step[1] ? a_reg[63:32] : a_reg[31:0];
  assign b_half    = step[0] ? b_reg[63:32] : b_reg[31:0];
  assign prod_next = a_half * b_half;

  // Align the registered partial product
  always_comb begin
    case (prod_pos)
      2'd0:    addend = {64'd0, prod};
      2'd1:    addend = {32'd0, prod, 32'd0};
      2'd2:    addend = {32'd0, prod, 32'd0};
      2'd3:    addend = {prod, 64'd0};
      default: addend = '0;
    endcase
  end

  // Step control; flag done for one cycle after the last add
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !cmd.start && busy && (step == mmm_pkg::MAC_LAST_STEP);
      if (cmd.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == mmm_pkg::MAC_LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_reg <= cmd.a;
      b_reg <= cmd.b;
      acc   <= {63'd0, {1'b0, cmd.c} + {1'b0, cmd.d}};
    end else if (busy) begin
      if (step != mmm_pkg::MAC_LAST_STEP) begin
        prod     <= prod_next;
        prod_pos <= step[1:0];
      end
      if (step != '0) begin
        acc <= acc + addend;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.hi   = acc[127:64];
  assign rsp.lo   = acc[63:0];

  `MMM_ASSERT_NOW(a_mac_start_idle, clk, rst, cmd.start, !busy, "mac started while busy")
  `MMM_ASSERT_NOW(a_mac_done_ends_busy, clk, rst, done, $past(busy) && !busy, "mac done without run")
  `MMM_ASSERT_NOW(a_mac_step_range, clk, rst, busy, step <= mmm_pkg::MAC_LAST_STEP, "mac step out of range")

endmodule

// File: rtl/montgomery_modular_multiplier.sv
// ----------------------------------------------------------------------------
// Montgomery modular multiplier (CIOS, word serial)
// Loads WORDS beats of x, y and modulus words, works out -m0^-1 mod 2^64,
// runs the interleaved multiply/reduce over a partial-sum RAM, applies the
// conditional subtraction and returns x*y*R^-1 mod m as WORDS result beats.
//
//   channel  handshake            payload     beats per product
//   in       in_valid/in_stall    in_item     WORDS
//   out      out_valid/out_stall  out_item    WORDS, last_word on the top one
//
// The first WORDS-1 input beats are stored. The last one starts a run set by
// the 63-step inverse lifting and the shared multiply-accumulate unit,
// which does 2*WORDS*WORDS+WORDS products.
// The partial-sum RAM is cleared during the inverse lifting; reset only
// returns control to the load state. Output stalls hold the emit step; the
// next input beat is taken while the final result beat still waits.
// ----------------------------------------------------------------------------
`include "montgomery_modular_multiplier_assert.svh"

module montgomery_modular_multiplier (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mmm_pkg::out_item_t out_item
);

  typedef enum logic [17:0] {
    S_LOAD   = 18'h00001,
    S_INV    = 18'h00002,
    S_RDX    = 18'h00004,
    S_LATX   = 18'h00008,
    S_A_RD   = 18'h00010,
    S_A_GO   = 18'h00020,
    S_A_WAIT = 18'h00040,
    S_A_TOP  = 18'h00080,
    S_U_GO   = 18'h00100,
    S_U_WAIT = 18'h00200,
    S_B_RD   = 18'h00400,
    S_B_GO   = 18'h00800,
    S_B_WAIT = 18'h01000,
    S_B_TOP  = 18'h02000,
    S_C_RD   = 18'h04000,
    S_C_EV   = 18'h08000,
    S_E_RD   = 18'h10000,
    S_E_OUT  = 18'h20000
  } state_t;

  state_t                              state;
  logic [mmm_pkg::IDX_W-1:0]           load_count;
  logic [mmm_pkg::IDX_W-1:0]           i_idx;
  logic [mmm_pkg::IDX_W-1:0]           j_idx;
  logic [mmm_pkg::INV_CNT_W-1:0]       inv_step;
  logic [mmm_pkg::INV_CNT_W-1:0]       clr_idx;

  logic [mmm_pkg::DATA_W-1:0]          m0;
  logic [mmm_pkg::DATA_W-1:0]          inv_acc;
  logic [mmm_pkg::DATA_W-1:0]          inv_val;
  logic [mmm_pkg::DATA_W-1:0]          inv_val_next;
  logic [mmm_pkg::DATA_W-1:0]          ninv;
  logic [mmm_pkg::DATA_W-1:0]          xi;
  logic [mmm_pkg::DATA_W-1:0]          u;
  logic [mmm_pkg::DATA_W-1:0]          carry;
  logic [mmm_pkg::DATA_W-1:0]          top_word;
  logic                                top_bit;
  logic                                borrow;
  logic                                sub_en;

  logic                                in_accept;
  logic                                load_last;
  logic                                j_last;
  logic                                out_free;
  logic [mmm_pkg::DATA_W:0]            top_sum;
  logic [mmm_pkg::DATA_W:0]            diff;

  logic [mmm_pkg::IDX_W-1:0]           rd_idx;
  logic [mmm_pkg::OPND_W-1:0]          opnd_rdata;
  mmm_pkg::in_item_t                   opnd_rd;
  logic                                ps_we;
  logic [mmm_pkg::IDX_W-1:0]           ps_waddr;
  logic [mmm_pkg::DATA_W-1:0]          ps_wdata;
  logic [mmm_pkg::DATA_W-1:0]          ps_rdata;

  mmm_pkg::mac_cmd_t                   mac_cmd;
  mmm_pkg::mac_rsp_t                   mac_rsp;

  assign in_stall  = (state != S_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign load_last = (load_count == mmm_pkg::IDX_LAST);
  assign j_last    = (j_idx == mmm_pkg::IDX_LAST);
  assign out_free  = !out_valid || !out_stall;
  assign opnd_rd   = mmm_pkg::in_item_t'(opnd_rdata);
  assign clr_idx   = inv_step - 6'd1;

  // Fold a carry into the top partial-sum word
  assign top_sum = {1'b0, top_word} + {1'b0, carry};

  // Low words minus modulus, word by word with borrow
  assign diff = {1'b0, ps_rdata} - {1'b0, opnd_rd.modulus_word} - {64'd0, borrow};

  // Inverse lifting: add m0 << k where bit k of the running product is set
  assign inv_val_next = inv_acc[inv_step] ? (inv_val | (64'd1 << inv_step)) : inv_val;

  // Shared read address for both RAMs
  always_comb begin
    case (state)
      S_RDX:   rd_idx = i_idx;
      S_A_TOP: rd_idx = '0;
      default: rd_idx = j_idx;
    endcase
  end

  // Partial-sum write port
  always_comb begin
    ps_we    = 1'b0;
    ps_waddr = j_idx;
    ps_wdata = mac_rsp.lo;
    case (state)
      S_INV: begin
        ps_we    = (clr_idx < 6'(mmm_pkg::WORDS));
        ps_waddr = clr_idx[mmm_pkg::IDX_W-1:0];
        ps_wdata = '0;
      end
      S_A_WAIT: begin
        ps_we = mac_rsp.done;
      end
      S_B_WAIT: begin
        ps_we    = mac_rsp.done && (j_idx != '0);
        ps_waddr = j_idx - mmm_pkg::IDX_W'(1);
      end
      S_B_TOP: begin
        ps_we    = 1'b1;
        ps_waddr = mmm_pkg::IDX_LAST;
        ps_wdata = top_sum[63:0];
      end
      default: ps_we = 1'b0;
    endcase
  end

  // Multiply-accumulate operands
  always_comb begin
    mac_cmd.start = state inside {S_A_GO, S_U_GO, S_B_GO};
    mac_cmd.a     = xi;
    mac_cmd.b     = opnd_rd.y_word;
    mac_cmd.c     = ps_rdata;
    mac_cmd.d     = (j_idx == '0) ? 64'd0 : carry;
    case (state)
      S_U_GO: begin
        mac_cmd.a = ps_rdata;
        mac_cmd.b = ninv;
        mac_cmd.c = '0;
        mac_cmd.d = '0;
      end
      S_B_GO: begin
        mac_cmd.a = u;
        mac_cmd.b = opnd_rd.modulus_word;
      end
      default: mac_cmd.a = xi;
    endcase
  end

  mmm_ram #(
    .WIDTH (mmm_pkg::OPND_W),
    .DEPTH (mmm_pkg::WORDS)
  ) u_opnd_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (load_count),
    .wdata (in_item),
    .raddr (rd_idx),
    .rdata (opnd_rdata)
  );

  mmm_ram #(
    .WIDTH (mmm_pkg::DATA_W),
    .DEPTH (mmm_pkg::WORDS)
  ) u_psum_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .raddr (rd_idx),
    .rdata (ps_rdata)
  );

  mmm_mac u_mac (
    .clk (clk),
    .rst (rst),
    .cmd (mac_cmd),
    .rsp (mac_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      i_idx      <= '0;
      j_idx      <= '0;
      inv_step   <= mmm_pkg::INV_FIRST;
      out_valid  <= 1'b0;
    end else begin
      // Raise the output beat from the emit step; drop it once taken
      if (state == S_E_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_accept) begin
            if (load_last) begin
              load_count <= '0;
              inv_step   <= mmm_pkg::INV_FIRST;
              state      <= S_INV;
            end else begin
              load_count <= load_count + mmm_pkg::IDX_W'(1);
            end
          end
        end
        S_INV: begin
          inv_step <= inv_step + 6'd1;
          if (inv_step == mmm_pkg::INV_LAST) begin
            i_idx <= '0;
            state <= S_RDX;
          end
        end
        S_RDX:  state <= S_LATX;
        S_LATX: begin
          j_idx <= '0;
          state <= S_A_RD;
        end
        S_A_RD: state <= S_A_GO;
        S_A_GO: state <= S_A_WAIT;
        S_A_WAIT: begin
          if (mac_rsp.done) begin
            if (j_last) begin
              state <= S_A_TOP;
            end else begin
              j_idx <= j_idx + mmm_pkg::IDX_W'(1);
              state <= S_A_RD;
            end
          end
        end
        S_A_TOP: state <= S_U_GO;
        S_U_GO:  state <= S_U_WAIT;
        S_U_WAIT: begin
          if (mac_rsp.done) begin
            j_idx <= '0;
            state <= S_B_RD;
          end
        end
        S_B_RD: state <= S_B_GO;
        S_B_GO: state <= S_B_WAIT;
        S_B_WAIT: begin
          if (mac_rsp.done) begin
            if (j_last) begin
              state <= S_B_TOP;
            end else begin
              j_idx <= j_idx + mmm_pkg::IDX_W'(1);
              state <= S_B_RD;
            end
          end
        end
        S_B_TOP: begin
          j_idx <= '0;
          if (i_idx == mmm_pkg::IDX_LAST) begin
            state <= S_C_RD;
          end else begin
            i_idx <= i_idx + mmm_pkg::IDX_W'(1);
            state <= S_RDX;
          end
        end
        S_C_RD: state <= S_C_EV;
        S_C_EV: begin
          if (j_last) begin
            j_idx <= '0;
            state <= S_E_RD;
          end else begin
            j_idx <= j_idx + mmm_pkg::IDX_W'(1);
            state <= S_C_RD;
          end
        end
        S_E_RD: state <= S_E_OUT;
        S_E_OUT: begin
          if (out_free) begin
            if (j_last) begin
              j_idx <= '0;
              state <= S_LOAD;
            end else begin
              j_idx <= j_idx + mmm_pkg::IDX_W'(1);
              state <= S_E_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (in_accept) begin
          if (load_count == '0) begin
            m0 <= in_item.modulus_word;
          end
          if (load_last) begin
            inv_acc  <= (load_count == '0) ? in_item.modulus_word : m0;
            inv_val  <= 64'd1;
            top_word <= '0;
            top_bit  <= 1'b0;
          end
        end
      end
      S_INV: begin
        if (inv_acc[inv_step]) begin
          inv_acc <= inv_acc + (m0 << inv_step);
        end
        inv_val <= inv_val_next;
        if (inv_step == mmm_pkg::INV_LAST) begin
          ninv <= 64'd0 - inv_val_next;
        end
      end
      S_LATX: xi <= opnd_rd.x_word;
      S_A_WAIT, S_B_WAIT: begin
        if (mac_rsp.done) begin
          carry <= mac_rsp.hi;
        end
      end
      S_A_TOP: begin
        top_word <= top_sum[63:0];
        top_bit  <= top_sum[64];
      end
      S_U_WAIT: begin
        if (mac_rsp.done) begin
          u <= mac_rsp.lo;
        end
      end
      S_B_TOP: begin
        top_word <= {63'd0, top_bit} + {63'd0, top_sum[64]};
        top_bit  <= 1'b0;
        borrow   <= 1'b0;
      end
      S_C_EV: begin
        if (j_last) begin
          sub_en <= (top_word != '0) || !diff[64];
          borrow <= 1'b0;
        end else begin
          borrow <= diff[64];
        end
      end
      S_E_OUT: begin
        if (out_free) begin
          out_item.result_word <= sub_en ? diff[63:0] : ps_rdata;
          out_item.last_word   <= j_last;
          borrow               <= diff[64];
        end
      end
      default: borrow <= borrow;
    endcase
  end

  `MMM_ASSERT_NEXT(a_last_beat_starts_inverse, clk, rst, in_accept && load_last, state == S_INV, "last input beat did not start the inverse")
  `MMM_ASSERT_NOW(a_out_beat_from_emit, clk, rst, $rose(out_valid), $past(state == S_E_OUT), "output beat loaded outside emit")
  `MMM_ASSERT_NOW(a_mac_done_while_waiting, clk, rst, mac_rsp.done, state == S_A_WAIT || state == S_U_WAIT || state == S_B_WAIT, "mac result arrived outside a wait step")

endmodule

// File: verif/montgomery_modular_multiplier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery modular multiplier testbench
// Feeds x, y and modulus words one beat at a time, least significant first,
// and predicts each Montgomery product with an independent CIOS model that
// lives in a small scoreboard class. Result beats are compared field by field
// in order. The sender runs in bursts with random gaps, the receiver stalls
// on a segmented random pattern, and one long receiver hold-off backs the
// block up into its input.
// ----------------------------------------------------------------------------
module montgomery_modular_multiplier_tb;

  localparam int OP_W = mmm_pkg::DATA_W * mmm_pkg::WORDS;
  localparam int RANDOM_PRODUCTS = 950 / mmm_pkg::WORDS;
  localparam int HOLD_OFF_CYCLES = 400;

  // Expected product words, plus the predictor state that builds them
  class product_checker;
    logic [mmm_pkg::DATA_W-1:0] x_words [mmm_pkg::WORDS];
    logic [mmm_pkg::DATA_W-1:0] y_words [mmm_pkg::WORDS];
    logic [mmm_pkg::DATA_W-1:0] mod_words [mmm_pkg::WORDS];
    logic [mmm_pkg::DATA_W-1:0] psum [mmm_pkg::WORDS+2];
    logic [mmm_pkg::DATA_W-1:0] neg_inv;
    int                         load_pos;
    mmm_pkg::out_item_t         expected_words [$];
    int                         mismatch_count;
    int                         result_beats;

    function new();
      load_pos = 0;
      neg_inv = '0;
      mismatch_count = 0;
      result_beats = 0;
    endfunction

    task report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch %0d at %0t: %s", mismatch_count, $realtime, msg);
    endtask

    // hi:lo = a*b + c + d
    function logic [2*mmm_pkg::DATA_W-1:0] mul_acc(input logic [mmm_pkg::DATA_W-1:0] a,
                                                   input logic [mmm_pkg::DATA_W-1:0] b,
                                                   input logic [mmm_pkg::DATA_W-1:0] c,
                                                   input logic [mmm_pkg::DATA_W-1:0] d);
      return (2*mmm_pkg::DATA_W)'(a) * (2*mmm_pkg::DATA_W)'(b)
             + (2*mmm_pkg::DATA_W)'(c) + (2*mmm_pkg::DATA_W)'(d);
    endfunction

    // -m0^-1 mod 2^64 by lifting one bit at a time
    function logic [mmm_pkg::DATA_W-1:0] lift_inverse(input logic [mmm_pkg::DATA_W-1:0] m0);
      logic [mmm_pkg::DATA_W-1:0] acc;
      logic [mmm_pkg::DATA_W-1:0] inv;
      acc = m0;
      inv = 64'd1;
      for (int i = 1; i < mmm_pkg::DATA_W; i++) begin
        if (acc[i]) begin
          acc = acc + (m0 << i);
          inv = inv + (64'd1 << i);
        end
      end
      return 64'd0 - inv;
    endfunction

    // Interleaved multiply and reduce, then the conditional subtraction
    function void predict_product();
      logic [2*mmm_pkg::DATA_W-1:0] p;
      logic [mmm_pkg::DATA_W-1:0]   carry;
      logic [mmm_pkg::DATA_W-1:0]   sum;
      logic [mmm_pkg::DATA_W-1:0]   u;
      logic [OP_W-1:0]              low;
      logic [OP_W-1:0]              modv;
      mmm_pkg::out_item_t           item;
      for (int k = 0; k < mmm_pkg::WORDS + 2; k++) psum[k] = '0;
      for (int i = 0; i < mmm_pkg::WORDS; i++) begin
        carry = '0;
        for (int j = 0; j < mmm_pkg::WORDS; j++) begin
          p = mul_acc(x_words[i], y_words[j], psum[j], carry);
          psum[j] = p[mmm_pkg::DATA_W-1:0];
          carry = p[2*mmm_pkg::DATA_W-1:mmm_pkg::DATA_W];
        end
        sum = psum[mmm_pkg::WORDS] + carry;
        psum[mmm_pkg::WORDS+1] = (sum < carry) ? 64'd1 : 64'd0;
        psum[mmm_pkg::WORDS] = sum;

        u = psum[0] * neg_inv;
        p = mul_acc(u, mod_words[0], psum[0], 64'd0);
        carry = p[2*mmm_pkg::DATA_W-1:mmm_pkg::DATA_W];
        for (int j = 1; j < mmm_pkg::WORDS; j++) begin
          p = mul_acc(u, mod_words[j], psum[j], carry);
          psum[j-1] = p[mmm_pkg::DATA_W-1:0];
          carry = p[2*mmm_pkg::DATA_W-1:mmm_pkg::DATA_W];
        end
        sum = psum[mmm_pkg::WORDS] + carry;
        psum[mmm_pkg::WORDS-1] = sum;
        psum[mmm_pkg::WORDS] = psum[mmm_pkg::WORDS+1] + ((sum < carry) ? 64'd1 : 64'd0);
        psum[mmm_pkg::WORDS+1] = '0;
      end

      for (int k = 0; k < mmm_pkg::WORDS; k++) begin
        low[k*mmm_pkg::DATA_W +: mmm_pkg::DATA_W] = psum[k];
        modv[k*mmm_pkg::DATA_W +: mmm_pkg::DATA_W] = mod_words[k];
      end
      // Subtract once when the top word is set or the low words reach m
      if (psum[mmm_pkg::WORDS] != 0 || low >= modv) begin
        low = low - modv;
      end
      for (int k = 0; k < mmm_pkg::WORDS; k++) begin
        item.result_word = low[k*mmm_pkg::DATA_W +: mmm_pkg::DATA_W];
        item.last_word = (k == mmm_pkg::WORDS - 1);
        expected_words.push_back(item);
      end
    endfunction

    // Store an accepted input beat; the top word kicks off a product
    function void take_operand_word(input mmm_pkg::in_item_t beat);
      x_words[load_pos] = beat.x_word;
      y_words[load_pos] = beat.y_word;
      mod_words[load_pos] = beat.modulus_word;
      if (load_pos + 1 < mmm_pkg::WORDS) begin
        load_pos++;
      end else begin
        load_pos = 0;
        neg_inv = lift_inverse(mod_words[0]);
        predict_product();
      end
    endfunction

    task check_result_word(input mmm_pkg::out_item_t got);
      mmm_pkg::out_item_t want;
      result_beats++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with no product pending: %h last %b",
                                  result_beats, got.result_word, got.last_word));
      end else begin
        want = expected_words.pop_front();
        if (got.result_word !== want.result_word) begin
          report_mismatch($sformatf("result beat %0d word %h, expected %h",
                                    result_beats, got.result_word, want.result_word));
        end
        if (got.last_word !== want.last_word) begin
          report_mismatch($sformatf("result beat %0d last %b, expected %b",
                                    result_beats, got.last_word, want.last_word));
        end
      end
    endtask

    function int pending_words();
      return expected_words.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mmm_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mmm_pkg::out_item_t out_item;

  product_checker board = new();
  int             burst_left = 0;
  bit             hold_off_req = 1'b0;

  montgomery_modular_multiplier dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the whole run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Stall the result channel in segments of random density; honor hold-offs
  initial begin
    int seg_left;
    int density;
    int hold_left;
    seg_left = 0;
    density = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(64, 1);
          case ($urandom_range(3, 0))
            0: density = 0;
            1: density = 25;
            2: density = 50;
            default: density = 90;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(99, 0) < density);
      end
    end
  end

  // Check every result beat taken by the receiver
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_result_word(out_item);
      end
    end
  end

  function automatic logic [mmm_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(15, 0));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_wide();
    logic [OP_W-1:0] v;
    for (int k = 0; k < mmm_pkg::WORDS; k++) begin
      v[k*mmm_pkg::DATA_W +: mmm_pkg::DATA_W] = pick_word();
    end
    return v;
  endfunction

  // Offer one beat; open a new burst after a random gap when one runs out
  task automatic send_beat(input mmm_pkg::in_item_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(64, 16)
                                               : $urandom_range(6, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (in_stall);
    board.take_operand_word(beat);
  endtask

  task automatic send_product(input logic [OP_W-1:0] x, input logic [OP_W-1:0] y,
                              input logic [OP_W-1:0] m);
    mmm_pkg::in_item_t beat;
    for (int k = 0; k < mmm_pkg::WORDS; k++) begin
      beat.x_word = x[k*mmm_pkg::DATA_W +: mmm_pkg::DATA_W];
      beat.y_word = y[k*mmm_pkg::DATA_W +: mmm_pkg::DATA_W];
      beat.modulus_word = m[k*mmm_pkg::DATA_W +: mmm_pkg::DATA_W];
      send_beat(beat);
    end
  endtask

  // Random product: mostly odd moduli with reduced operands
  task automatic send_random_product();
    logic [OP_W-1:0] x;
    logic [OP_W-1:0] y;
    logic [OP_W-1:0] m;
    case ($urandom_range(19, 0))
      0: m = pick_wide() & ~OP_W'(1);
      1, 2: m = OP_W'({$urandom(), $urandom()} | 64'd1);
      3: m = '1;
      default: m = pick_wide() | OP_W'(1);
    endcase
    x = pick_wide();
    y = pick_wide();
    if (m != 0 && $urandom_range(19, 0) > 2) begin
      x = x % m;
      y = y % m;
    end
    send_product(x, y, m);
  endtask

  initial begin
    logic [OP_W-1:0] m;
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, tiny, even and zero moduli, unreduced operands
    send_product('0, '0, '1);
    send_product(~OP_W'(1), ~OP_W'(1), '1);
    send_product('0, '0, OP_W'(1));
    send_product('1, '1, OP_W'(1));
    send_product(pick_wide(), pick_wide(), ~OP_W'(1));
    send_product(pick_wide(), pick_wide(), '0);
    m = pick_wide() | OP_W'(1);
    send_product(OP_W'(1), OP_W'(1), m);
    send_product(m - 1, m - 1, m);
    send_product(m, m, m);
    send_product('1, '1, OP_W'(3));
    send_product(OP_W'(5), OP_W'(7), OP_W'({$urandom(), $urandom()} | 64'd1));
    send_product({(OP_W/2){2'b01}}, {(OP_W/2){2'b10}}, '1);

    // Random products, with one long receiver hold-off and one full drain
    for (int n = 0; n < RANDOM_PRODUCTS; n++) begin
      if (n == RANDOM_PRODUCTS / 3) begin
        hold_off_req = 1'b1;
      end
      if (n == 2 * RANDOM_PRODUCTS / 3) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_words() != 0) @(posedge clk);
      end
      send_random_product();
    end

    // Drain the remaining results, then allow for stray beats
    in_valid <= 1'b0;
    waited = 0;
    while (board.pending_words() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (board.pending_words() != 0) begin
      board.report_mismatch($sformatf("%0d result beats never arrived",
                                      board.pending_words()));
    end
    if (board.mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
